// ===== src/mbsh_pkg.sv =====
// ============================================================================
// mbsh_pkg: shared definitions for the masked block string hash
// Constants, the controller state type, the multiplier request and response
// types, the length mask and the byte masking function for one input word.
// ============================================================================
package mbsh_pkg;

	localparam int LENGTH_BITS  = 32;
	localparam int LEN_IN_W     = 32;
	localparam int WORD_W       = 64;
	localparam int BLOCK_SHIFT  = 5;
	localparam int BLK_W        = LENGTH_BITS - BLOCK_SHIFT;
	localparam int CNT_W        = BLOCK_SHIFT + 1;
	localparam int LANE_W       = 2;
	localparam int BYTES_W      = 8;
	localparam int DIGIT_W      = 16;
	localparam int DIGITS       = WORD_W / DIGIT_W;
	localparam int DIGIT_CNT_W  = $clog2(DIGITS);
	localparam int MIX_SHIFT    = 47;

	localparam logic [WORD_W-1:0] HASH_MUL    = 64'hc6a4a7935bd1e995;
	localparam logic [CNT_W-1:0]  BLOCK_BYTES = CNT_W'(32);
	localparam logic [LANE_W-1:0] LAST_LANE   = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEN_MUL,
		ST_MIX_MUL,
		ST_FIN_MUL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] operand;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] product;
	} mul_rsp_t;

	// Keeps the low LENGTH_BITS bits of the length field.
	function automatic logic [LENGTH_BITS-1:0] mask_length(input logic [LEN_IN_W-1:0] s);
		logic [WORD_W-1:0] wide;
		wide = WORD_W'(s);
		return wide[LENGTH_BITS-1:0];
	endfunction

	// Zeroes the bytes at or past the block's count, then adds the count to each byte.
	function automatic logic [WORD_W-1:0] prep_word(input logic [WORD_W-1:0] w,
			input logic [LANE_W-1:0] lane, input logic [CNT_W-1:0] count);
		logic [WORD_W-1:0] r;
		logic [7:0]        b;
		logic [CNT_W-1:0]  idx;
		r = '0;
		for (int k = 0; k < BYTES_W; k++) begin
			idx = {1'b0, lane, 3'(k)};
			b   = w[8*k +: 8];
			if (idx >= count) begin
				b = 8'h00;
			end
			b = b + 8'(count);
			r[8*k +: 8] = b;
		end
		return r;
	endfunction

endpackage

// ===== src/mbsh_if.sv =====
// ============================================================================
// mbsh_if: stream channels of the masked block string hash
// The word channel carries string words with the length on the first beat;
// the hash channel carries one finalized hash per string.
// ============================================================================
interface mbsh_word_if;
	logic        valid;
	logic        ready;
	logic [63:0] word_data;
	logic        first_word;
	logic [31:0] string_length;

	modport source (output valid, word_data, first_word, string_length, input ready);
	modport sink   (input valid, word_data, first_word, string_length, output ready);
endinterface

interface mbsh_hash_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;

	modport source (output valid, hash_value, input ready);
	modport sink   (input valid, hash_value, output ready);
endinterface

// ===== src/mbsh_mul.sv =====
// ============================================================================
// mbsh_mul: digit-serial multiply by the hash constant
// Takes a 64-bit operand and returns its product with the hash constant
// modulo 2^64, one 16-bit digit of the operand per cycle.
// ============================================================================
module mbsh_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  mbsh_pkg::mul_req_t  req,
	output mbsh_pkg::mul_rsp_t  rsp
);

	logic [mbsh_pkg::WORD_W-1:0]      a_q;
	logic [mbsh_pkg::WORD_W-1:0]      m_q;
	logic [mbsh_pkg::WORD_W-1:0]      acc_q;
	logic [mbsh_pkg::DIGIT_CNT_W-1:0] cnt_q;
	logic                             busy_q;
	logic                             done_q;
	logic [mbsh_pkg::WORD_W-1:0]      term;

	// The constant is shifted up one digit per cycle, so each partial product
	// lands at its weight and bits above 64 simply fall away.
	assign term = mbsh_pkg::WORD_W'(a_q[mbsh_pkg::DIGIT_W-1:0]) * m_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + mbsh_pkg::DIGIT_CNT_W'(1);
			if (cnt_q == mbsh_pkg::DIGIT_CNT_W'(mbsh_pkg::DIGITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.operand;
			m_q   <= mbsh_pkg::HASH_MUL;
			acc_q <= '0;
		end else if (busy_q) begin
			a_q   <= a_q >> mbsh_pkg::DIGIT_W;
			m_q   <= m_q << mbsh_pkg::DIGIT_W;
			acc_q <= acc_q + term;
		end
	end

	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

endmodule

// ===== src/masked_block_string_hash_top.sv =====
// ============================================================================
// masked_block_string_hash_top: masked block string hash
// Hashes strings given as 64-bit words in 32-byte blocks and returns one
// finalized 64-bit hash per string.
// ============================================================================
// The block takes one word at a time and works on it to the end before it
// takes the next. Each word is accepted, passed through the 16-bit
// digit-serial multiplier, and its result folded into the hash state.
// A string's first word waits for the length multiply before its own, and the
// last word is followed by the finalizing multiply. A finished hash waits
// in an output register; the next string's words are taken meanwhile, and the
// block only stalls if a second hash is ready before the first was taken.
// A word that does not start a string while none is in progress is dropped.
module masked_block_string_hash_top (
	input  logic               clk,
	input  logic               arst_n,
	mbsh_word_if.sink          word_in,
	mbsh_hash_if.source        hash_out
);

	mbsh_pkg::state_t state_q, state_d;

	logic                           active_q;
	logic [mbsh_pkg::WORD_W-1:0]    w_q;
	logic [mbsh_pkg::WORD_W-1:0]    h_q;
	logic [mbsh_pkg::BLK_W-1:0]     blk_q;
	logic [mbsh_pkg::LANE_W-1:0]    lane_q;
	logic [mbsh_pkg::BLK_W-1:0]     last_blk_q;
	logic [mbsh_pkg::CNT_W-1:0]     tail_q;
	logic                           out_valid_q;
	logic [mbsh_pkg::WORD_W-1:0]    out_data_q;

	mbsh_pkg::mul_req_t             mul_req;
	mbsh_pkg::mul_rsp_t             mul_rsp;

	logic                           accept;
	logic                           slot_free;
	logic                           is_last;
	logic [mbsh_pkg::CNT_W-1:0]     count;
	logic [mbsh_pkg::WORD_W-1:0]    w_sel;
	logic [mbsh_pkg::WORD_W-1:0]    prepped;
	logic [mbsh_pkg::WORD_W-1:0]    mixed;
	logic [mbsh_pkg::WORD_W-1:0]    fin_pre;
	logic [mbsh_pkg::WORD_W-1:0]    fin_out;
	logic [mbsh_pkg::LENGTH_BITS-1:0] len;
	logic [mbsh_pkg::LENGTH_BITS-1:0] len_m1;

	assign accept    = word_in.valid && word_in.ready;
	assign slot_free = !out_valid_q || hash_out.ready;
	assign is_last   = (blk_q == last_blk_q) && (lane_q == mbsh_pkg::LAST_LANE);
	assign count     = (blk_q == last_blk_q) ? tail_q : mbsh_pkg::BLOCK_BYTES;
	assign w_sel     = (state_q == mbsh_pkg::ST_IDLE) ? word_in.word_data : w_q;
	assign prepped   = mbsh_pkg::prep_word(w_sel, lane_q, count);
	assign mixed     = mul_rsp.product ^ (mul_rsp.product >> mbsh_pkg::MIX_SHIFT);
	assign fin_pre   = mixed ^ (mixed >> mbsh_pkg::MIX_SHIFT);
	assign fin_out   = mixed;
	assign len       = mbsh_pkg::mask_length(word_in.string_length);
	assign len_m1    = len - mbsh_pkg::LENGTH_BITS'(1);

	mbsh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mbsh_pkg::ST_IDLE: begin
				if (accept && word_in.first_word) begin
					state_d = mbsh_pkg::ST_LEN_MUL;
				end else if (accept && active_q) begin
					state_d = mbsh_pkg::ST_MIX_MUL;
				end
			end
			mbsh_pkg::ST_LEN_MUL: begin
				if (mul_rsp.done) begin
					state_d = mbsh_pkg::ST_MIX_MUL;
				end
			end
			mbsh_pkg::ST_MIX_MUL: begin
				if (mul_rsp.done) begin
					state_d = is_last ? mbsh_pkg::ST_FIN_MUL : mbsh_pkg::ST_IDLE;
				end
			end
			mbsh_pkg::ST_FIN_MUL: begin
				if (mul_rsp.done) begin
					state_d = mbsh_pkg::ST_EMIT;
				end
			end
			mbsh_pkg::ST_EMIT: begin
				if (slot_free) begin
					state_d = mbsh_pkg::ST_IDLE;
				end
			end
			default: state_d = mbsh_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the controller. Ready is high in idle, so valid alone marks a beat.
	always_comb begin
		word_in.ready   = 1'b0;
		mul_req.start   = 1'b0;
		mul_req.operand = '0;
		case (state_q)
			mbsh_pkg::ST_IDLE: begin
				word_in.ready = 1'b1;
				if (word_in.valid && word_in.first_word) begin
					mul_req.start   = 1'b1;
					mul_req.operand = mbsh_pkg::WORD_W'(len);
				end else if (word_in.valid && active_q) begin
					mul_req.start   = 1'b1;
					mul_req.operand = h_q ^ prepped;
				end
			end
			mbsh_pkg::ST_LEN_MUL: begin
				mul_req.start   = mul_rsp.done;
				mul_req.operand = mul_rsp.product ^ prepped;
			end
			mbsh_pkg::ST_MIX_MUL: begin
				mul_req.start   = mul_rsp.done && is_last;
				mul_req.operand = fin_pre;
			end
			mbsh_pkg::ST_FIN_MUL, mbsh_pkg::ST_EMIT: begin
				mul_req.start = 1'b0;
			end
			default: begin
				mul_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mbsh_pkg::ST_IDLE;
			active_q    <= 1'b0;
			blk_q       <= '0;
			lane_q      <= '0;
			last_blk_q  <= '0;
			tail_q      <= '0;
			h_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mbsh_pkg::ST_IDLE && accept && word_in.first_word) begin
				active_q <= 1'b1;
				blk_q    <= '0;
				lane_q   <= '0;
				if (len == '0) begin
					last_blk_q <= '0;
					tail_q     <= '0;
				end else begin
					last_blk_q <= len_m1[mbsh_pkg::LENGTH_BITS-1:mbsh_pkg::BLOCK_SHIFT];
					tail_q     <= mbsh_pkg::CNT_W'(len_m1[mbsh_pkg::BLOCK_SHIFT-1:0])
						+ mbsh_pkg::CNT_W'(1);
				end
			end
			if (state_q == mbsh_pkg::ST_MIX_MUL && mul_rsp.done) begin
				h_q <= mixed;
				if (is_last) begin
					active_q <= 1'b0;
					blk_q    <= '0;
					lane_q   <= '0;
				end else begin
					lane_q <= lane_q + mbsh_pkg::LANE_W'(1);
					if (lane_q == mbsh_pkg::LAST_LANE) begin
						blk_q <= blk_q + mbsh_pkg::BLK_W'(1);
					end
				end
			end
			if (state_q == mbsh_pkg::ST_EMIT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (hash_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mbsh_pkg::ST_IDLE && accept) begin
			w_q <= word_in.word_data;
		end
		if (state_q == mbsh_pkg::ST_EMIT && slot_free) begin
			out_data_q <= fin_out;
		end
	end

	assign hash_out.valid      = out_valid_q;
	assign hash_out.hash_value = out_data_q;

`ifndef SYNTH
	a_done_in_mul_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == mbsh_pkg::ST_LEN_MUL || state_q == mbsh_pkg::ST_MIX_MUL
			|| state_q == mbsh_pkg::ST_FIN_MUL))
		else $error("multiplier finished outside a multiply state");
	a_blk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> blk_q <= last_blk_q)
		else $error("block index ran past the last block");
	a_first_starts_len: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && word_in.first_word) |=> (state_q == mbsh_pkg::ST_LEN_MUL && active_q))
		else $error("first beat did not start the length multiply");
	a_emit_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mbsh_pkg::ST_FIN_MUL || state_q == mbsh_pkg::ST_EMIT) |-> !active_q)
		else $error("string still active while its hash is finalized");
`endif

endmodule

// ===== verif/tb_masked_block_string_hash_top.sv =====
// ----------------------------------------------------------------------------
// tb_masked_block_string_hash_top: string hash stream testbench
// Feeds strings as 64-bit word beats and compares every hash that comes out
// with a hash worked out inside the testbench. A short directed table comes
// first, followed by random strings, abandoned strings and stray words, with
// random idle bursts on both channels and one long hold on the hash side.
// ----------------------------------------------------------------------------
module tb_masked_block_string_hash_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 650;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 40;

	typedef enum logic {
		CHK_MODEL,
		CHK_NO_HASH
	} chk_kind_t;

	typedef struct packed {
		logic [63:0] word;
		logic        first;
		logic [31:0] len;
		chk_kind_t   chk;
	} dir_row_t;

	localparam int DIR_ROWS = 23;
	localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
		// A stray word right after reset leaves no trace.
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'hFFFF_FFFF, CHK_NO_HASH},
		// Empty string: one block of count zero.
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'd0, CHK_MODEL},
		'{64'h0000_0000_0000_0000, 1'b0, 32'hFFFF_FFFF, CHK_MODEL},
		'{64'h0123_4567_89AB_CDEF, 1'b0, 32'd0, CHK_MODEL},
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0, CHK_MODEL},
		// One byte long.
		'{64'h0000_0000_0000_00FF, 1'b1, 32'd1, CHK_MODEL},
		'{64'h8000_0000_0000_0001, 1'b0, 32'd0, CHK_MODEL},
		'{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 32'd0, CHK_MODEL},
		'{64'h5555_5555_5555_5555, 1'b0, 32'd0, CHK_MODEL},
		// Longest length, dropped after one beat by a new string.
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF, CHK_MODEL},
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'd32, CHK_MODEL},
		'{64'hFEDC_BA98_7654_3210, 1'b0, 32'd0, CHK_MODEL},
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0, CHK_MODEL},
		'{64'h0000_0000_0000_0000, 1'b0, 32'd0, CHK_MODEL},
		'{64'h0000_0000_0000_0001, 1'b0, 32'd0, CHK_NO_HASH},
		// Second block holds a single byte.
		'{64'h0F1E_2D3C_4B5A_6978, 1'b1, 32'd33, CHK_MODEL},
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h8000_0000, CHK_MODEL},
		'{64'h0000_0000_0000_0000, 1'b0, 32'd0, CHK_MODEL},
		'{64'hC3C3_C3C3_C3C3_C3C3, 1'b0, 32'd0, CHK_MODEL},
		'{64'hFFFF_FFFF_FFFF_FF7F, 1'b0, 32'd0, CHK_MODEL},
		'{64'h1111_2222_3333_4444, 1'b0, 32'd0, CHK_MODEL},
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0, CHK_MODEL},
		'{64'h0000_0000_0000_0000, 1'b0, 32'd0, CHK_MODEL}
	};

	logic clk;
	logic arst_n;

	mbsh_word_if word_ch();
	mbsh_hash_if hash_ch();

	masked_block_string_hash_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.word_in  (word_ch),
		.hash_out (hash_ch)
	);

	// Running hash state of the string in progress.
	logic [63:0] str_hash;
	logic [63:0] str_len;
	int unsigned str_pos;
	logic        str_busy;

	logic [63:0] hash_expect_q[$];
	int          err_cnt;
	int          items_taken;
	logic        idle_on;
	int          squeeze_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR %0t ns: %s", $realtime, msg);
		err_cnt++;
	endtask

	function automatic logic [63:0] length_in_use(input logic [31:0] l);
		return 64'(l) & ((64'd1 << mbsh_pkg::LENGTH_BITS) - 64'd1);
	endfunction

	// Folds one accepted word into the running hash; done marks the last word.
	function automatic void hash_word(input logic [63:0] w, input logic f,
			input logic [31:0] l, output logic took, output logic done,
			output logic [63:0] fin);
		logic [63:0] nblk;
		logic [63:0] blk;
		logic [63:0] cnt;
		logic [63:0] idx;
		logic [63:0] prep;
		logic [63:0] h;
		logic [7:0]  bt;
		took = 1'b0;
		done = 1'b0;
		fin  = '0;
		if (f) begin
			str_len  = length_in_use(l);
			str_hash = str_len * mbsh_pkg::HASH_MUL;
			str_pos  = 0;
			str_busy = 1'b1;
		end else if (!str_busy) begin
			return;
		end
		took = 1'b1;
		nblk = (str_len == 0) ? 64'd1 : (str_len + 64'd31) >> 5;
		blk  = 64'(str_pos) >> 2;
		cnt  = (blk == nblk - 64'd1) ? str_len - (blk << 5) : 64'd32;
		for (int k = 0; k < 8; k++) begin
			idx = 64'(str_pos % 4) * 8 + 64'(k);
			bt  = (idx >= cnt) ? 8'h00 : w[8*k +: 8];
			prep[8*k +: 8] = bt + cnt[7:0];
		end
		h = str_hash ^ prep;
		h = h * mbsh_pkg::HASH_MUL;
		h = h ^ (h >> mbsh_pkg::MIX_SHIFT);
		str_hash = h;
		if (64'(str_pos) == nblk * 4 - 64'd1) begin
			h = h ^ (h >> mbsh_pkg::MIX_SHIFT);
			h = h * mbsh_pkg::HASH_MUL;
			h = h ^ (h >> mbsh_pkg::MIX_SHIFT);
			fin      = h;
			done     = 1'b1;
			str_busy = 1'b0;
			str_pos  = 0;
		end else begin
			str_pos++;
		end
	endfunction

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 7))
			0: return '1;
			1: return '0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Offers one beat, waits for the handshake, then predicts its effect.
	task automatic send_word(input logic [63:0] w, input logic f, input logic [31:0] l,
			input chk_kind_t chk);
		logic        took;
		logic        done;
		logic [63:0] fin;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			word_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		word_ch.valid         <= 1'b1;
		word_ch.word_data     <= w;
		word_ch.first_word    <= f;
		word_ch.string_length <= l;
		do @(posedge clk); while (!word_ch.ready);
		hash_word(w, f, l, took, done, fin);
		if (took) items_taken++;
		if (done && chk == CHK_MODEL) hash_expect_q.push_back(fin);
	endtask

	// Sends a whole string, or only its first cut beats when cut is positive.
	task automatic send_string(input logic [31:0] len, input int cut);
		logic [63:0] mlen;
		logic [63:0] total;
		int          n;
		mlen  = length_in_use(len);
		total = (mlen == 0) ? 64'd4 : ((mlen + 64'd31) >> 5) * 4;
		n     = (cut > 0) ? cut : int'(total);
		for (int k = 0; k < n; k++) begin
			send_word(rand_word(), k == 0, (k == 0) ? len : $urandom, CHK_MODEL);
		end
	endtask

	initial begin
		int pick;
		err_cnt     = 0;
		items_taken = 0;
		idle_on     = 1'b1;
		squeeze_req = 0;
		str_hash    = '0;
		str_len     = '0;
		str_pos     = 0;
		str_busy    = 1'b0;
		arst_n                <= 1'b0;
		word_ch.valid         <= 1'b0;
		word_ch.word_data     <= '0;
		word_ch.first_word    <= 1'b0;
		word_ch.string_length <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			send_word(DIR_TBL[r].word, DIR_TBL[r].first, DIR_TBL[r].len, DIR_TBL[r].chk);
		end

		while (items_taken < ITEM_TARGET) begin
			if (squeeze_req == 0 && items_taken >= 300) begin
				// Short strings pile up behind the held hash channel.
				squeeze_req++;
				repeat (6) send_string($urandom_range(0, 40), 0);
			end
			if (items_taken >= ITEM_TARGET - 90) idle_on = 1'b0;
			pick = $urandom_range(0, 19);
			if (pick < 15) begin
				send_string(($urandom_range(0, 9) == 0) ? $urandom_range(0, 300)
						: $urandom_range(0, 100), 0);
			end else if (pick < 18) begin
				send_string($urandom, $urandom_range(1, 3));
			end else begin
				send_word(rand_word(), 1'b0, $urandom, CHK_MODEL);
			end
		end
		word_ch.valid <= 1'b0;

		while (hash_expect_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Hash side: random stalls, one long hold on request, and the compare.
	initial begin
		int          hold;
		int          squeeze_seen;
		logic [63:0] want;
		hold         = 0;
		squeeze_seen = 0;
		hash_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hash_ch.valid && hash_ch.ready) begin
				if (hash_expect_q.size() == 0) begin
					report_mismatch($sformatf("hash %h with no string pending",
							hash_ch.hash_value));
				end else begin
					want = hash_expect_q.pop_front();
					if (hash_ch.hash_value !== want) begin
						report_mismatch($sformatf("hash_value %h, expected %h",
								hash_ch.hash_value, want));
					end
				end
			end
			if (squeeze_seen != squeeze_req) begin
				squeeze_seen = squeeze_req;
				hold = HOLD_CYCLES;
			end else if (hold == 0 && idle_on && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 9);
			end
			if (hold > 0) begin
				hash_ch.ready <= 1'b0;
				hold--;
			end else begin
				hash_ch.ready <= 1'b1;
			end
		end
	end

	// Ends the run when no beat moves on either channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ((word_ch.valid && word_ch.ready) || (hash_ch.valid && hash_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

endmodule

// ===== files.f =====
src/mbsh_pkg.sv
src/mbsh_if.sv
src/mbsh_mul.sv
src/masked_block_string_hash_top.sv
verif/tb_masked_block_string_hash_top.sv
